/* rtl/assert_macros.svh */
// assertion helpers used by edf_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define EDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("edf assertion failed");
`define EDF_NEVER(lbl, clk, rstn, cond) \
  `EDF_ASSERT(lbl, clk, rstn, !(cond))
`else
`define EDF_ASSERT(lbl, clk, rstn, prop)
`define EDF_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/edf_pkg.sv */
`default_nettype none
package edf_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TASK_ID_W = 4;
  localparam int TIME_W = 32;

  localparam logic [1:0] OP_TICK         = 2'd0;
  localparam logic [1:0] OP_CREATE_PLAIN = 2'd1;
  localparam logic [1:0] OP_CREATE_RT    = 2'd2;
  localparam logic [1:0] OP_SELECT       = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_IDLE = 2'd2;
  localparam logic [1:0] STAT_TICK = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] start_ms;
    logic [TIME_W-1:0] relative_deadline_ms;
    logic              task_done;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [TASK_ID_W-1:0] task_id;
    logic                 is_realtime;
    logic [TIME_W-1:0]    now_ms;
    logic [TIME_W-1:0]    met_count;
    logic [TIME_W-1:0]    miss_count;
  } rsp_t;

  typedef struct packed {
    logic ins;
    logic app;
    logic rem;
    logic pop;
  } list_ctl_t;

endpackage
`default_nettype wire

/* rtl/edf_task_scheduler_top.sv */
// earliest-deadline-first task scheduler
// input channel: in_valid_i / in_stall_o carry one request (op, start_ms,
// relative_deadline_ms, task_done); output channel: out_valid_o / out_stall_i
// carry one response per request, in request order.
// a two-entry request queue feeds a sequencer that owns the pending, ready
// and plain-task lists (shift-register rows with per-entry compare).
// tick and create load the response register as the request is accepted.
// select runs release, retire, jump, release and pick steps; release moves
// due tasks to ready one by one, plus a step to retire or requeue a running task.
// one request is worked at a time; the queue keeps taking requests
// until it holds two.
// a stalled response holds in the output register; the sequencer then waits
// before starting the next request, and the queue fills and raises in_stall_o.
// reset clears the lists, slot flags, clock and counters at once; the block
// takes requests in the first cycle after reset.
`default_nettype none
module edf_task_scheduler_top #(
  parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  edf_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output edf_pkg::rsp_t out_rsp_o
);
  import edf_pkg::*;

  localparam int ID_W  = $clog2(MAX_TASKS);
  localparam int LEN_W = $clog2(MAX_TASKS + 1);

  logic q_valid, q_pop;
  req_t q_req;

  edf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  edf_back #(.N(MAX_TASKS), .ID_W(ID_W), .LEN_W(LEN_W)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .out_valid_o, .out_stall_i, .out_rsp_o
  );

endmodule
`default_nettype wire

/* rtl/edf_front.sv */
`default_nettype none
module edf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  edf_pkg::req_t in_req_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output edf_pkg::req_t q_req_o
);
  import edf_pkg::*;

  req_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/edf_list.sv */
`default_nettype none
module edf_list #(
  parameter int N     = edf_pkg::MAX_TASKS_DEF,
  parameter int ID_W  = $clog2(N),
  parameter int LEN_W = $clog2(N + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  edf_pkg::list_ctl_t        ctl_i,
  input  logic [ID_W-1:0]           id_i,
  input  logic [edf_pkg::TIME_W-1:0] key_i,
  input  logic [edf_pkg::TIME_W-1:0] aux_i,
  input  logic [ID_W-1:0]           rem_id_i,
  output logic [ID_W-1:0]           head_id_o,
  output logic [edf_pkg::TIME_W-1:0] head_key_o,
  output logic [edf_pkg::TIME_W-1:0] head_aux_o,
  output logic [LEN_W-1:0]          len_o,
  output logic [edf_pkg::TIME_W-1:0] found_key_o
);
  import edf_pkg::*;

  logic [ID_W-1:0]   id_q  [N];
  logic [TIME_W-1:0] key_q [N];
  logic [TIME_W-1:0] aux_q [N];
  logic [LEN_W-1:0]  len_q, len_d;

  logic [ID_W-1:0]   prv_id [N], nxt_id [N];
  logic [TIME_W-1:0] prv_key [N], nxt_key [N];
  logic [TIME_W-1:0] prv_aux [N], nxt_aux [N];
  logic [N-1:0] vld, gt, gt_sh, put, match, after;

  assign head_id_o  = id_q[0];
  assign head_key_o = key_q[0];
  assign head_aux_o = aux_q[0];
  assign len_o      = len_q;

  always_comb begin
    found_key_o = '0;
    for (int i = 0; i < N; i++) begin
      vld[i]   = LEN_W'(i) < len_q;
      // first entry with a later key takes the new one, equal keys stay ahead
      gt[i]    = !vld[i] || (key_q[i] > key_i);
      match[i] = vld[i] && (id_q[i] == rem_id_i);
      if (match[i]) begin
        found_key_o = key_q[i];
      end
    end
    gt_sh = {gt[N-2:0], 1'b0};
    put   = gt & ~gt_sh;
    after[0] = match[0];
    for (int i = 1; i < N; i++) begin
      after[i] = after[i-1] | match[i];
    end
    prv_id[0]  = id_q[0];
    prv_key[0] = key_q[0];
    prv_aux[0] = aux_q[0];
    for (int i = 1; i < N; i++) begin
      prv_id[i]  = id_q[i-1];
      prv_key[i] = key_q[i-1];
      prv_aux[i] = aux_q[i-1];
    end
    for (int i = 0; i < N - 1; i++) begin
      nxt_id[i]  = id_q[i+1];
      nxt_key[i] = key_q[i+1];
      nxt_aux[i] = aux_q[i+1];
    end
    nxt_id[N-1]  = id_q[N-1];
    nxt_key[N-1] = key_q[N-1];
    nxt_aux[N-1] = aux_q[N-1];

    len_d = len_q;
    if ((ctl_i.ins || ctl_i.app) && (len_q != LEN_W'(N))) begin
      len_d = len_q + LEN_W'(1);
    end else if (ctl_i.rem && (|match)) begin
      len_d = len_q - LEN_W'(1);
    end else if (ctl_i.pop && (len_q != '0)) begin
      len_d = len_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      if (ctl_i.ins) begin
        if (put[i]) begin
          id_q[i]  <= id_i;
          key_q[i] <= key_i;
          aux_q[i] <= aux_i;
        end else if (gt_sh[i]) begin
          id_q[i]  <= prv_id[i];
          key_q[i] <= prv_key[i];
          aux_q[i] <= prv_aux[i];
        end
      end else if (ctl_i.app) begin
        if (LEN_W'(i) == len_q) begin
          id_q[i]  <= id_i;
          key_q[i] <= key_i;
          aux_q[i] <= aux_i;
        end
      end else if ((ctl_i.rem && after[i]) || ctl_i.pop) begin
        id_q[i]  <= nxt_id[i];
        key_q[i] <= nxt_key[i];
        aux_q[i] <= nxt_aux[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/edf_back.sv */
`default_nettype none
`include "assert_macros.svh"
module edf_back #(
  parameter int N     = edf_pkg::MAX_TASKS_DEF,
  parameter int ID_W  = $clog2(N),
  parameter int LEN_W = $clog2(N + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  edf_pkg::req_t q_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output edf_pkg::rsp_t out_rsp_o
);
  import edf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REL1 = 3'd1;
  localparam logic [2:0] S_RET  = 3'd2;
  localparam logic [2:0] S_REQ  = 3'd3;
  localparam logic [2:0] S_JUMP = 3'd4;
  localparam logic [2:0] S_REL2 = 3'd5;
  localparam logic [2:0] S_PICK = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [TIME_W-1:0] clock_q, clock_d;
  logic [TIME_W-1:0] met_q, met_d, miss_q, miss_d;
  logic [N-1:0]      used_q, used_d, rt_q, rt_d;
  logic              run_valid_q, run_valid_d;
  logic [ID_W-1:0]   run_id_q, run_id_d;
  logic              first_q, first_d;
  req_t              req_q, req_d;
  logic [TIME_W-1:0] ret_dl_q, ret_dl_d;
  rsp_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  list_ctl_t         p_ctl, r_ctl, f_ctl;
  logic [ID_W-1:0]   p_id, r_id, f_id, r_rem, f_rem;
  logic [TIME_W-1:0] p_key, p_aux, r_key;
  logic [ID_W-1:0]   p_head_id, r_head_id, f_head_id;
  logic [TIME_W-1:0] p_head_key, p_head_aux, r_found;
  logic [LEN_W-1:0]  p_len, r_len, f_len;

  logic              free_found;
  logic [ID_W-1:0]   free_id;
  logic [TIME_W:0]   dl_sum;
  logic [TIME_W-1:0] dl_sat;
  logic              out_free;
  logic              wr;
  logic [1:0]        wr_status;
  logic [ID_W-1:0]   wr_id;
  logic              wr_rt;

  edf_list #(.N(N), .ID_W(ID_W), .LEN_W(LEN_W)) u_pend (
    .clk_i, .rst_ni, .ctl_i(p_ctl), .id_i(p_id), .key_i(p_key), .aux_i(p_aux),
    .rem_id_i(p_id), .head_id_o(p_head_id), .head_key_o(p_head_key),
    .head_aux_o(p_head_aux), .len_o(p_len), .found_key_o()
  );

  edf_list #(.N(N), .ID_W(ID_W), .LEN_W(LEN_W)) u_ready (
    .clk_i, .rst_ni, .ctl_i(r_ctl), .id_i(r_id), .key_i(r_key), .aux_i(r_key),
    .rem_id_i(r_rem), .head_id_o(r_head_id), .head_key_o(),
    .head_aux_o(), .len_o(r_len), .found_key_o(r_found)
  );

  edf_list #(.N(N), .ID_W(ID_W), .LEN_W(LEN_W)) u_fifo (
    .clk_i, .rst_ni, .ctl_i(f_ctl), .id_i(f_id), .key_i('0), .aux_i('0),
    .rem_id_i(f_rem), .head_id_o(f_head_id), .head_key_o(),
    .head_aux_o(), .len_o(f_len), .found_key_o()
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign dl_sum      = {1'b0, q_req_i.start_ms} + {1'b0, q_req_i.relative_deadline_ms};
  assign dl_sat      = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_id    = ID_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    clock_d     = clock_q;
    met_d       = met_q;
    miss_d      = miss_q;
    used_d      = used_q;
    rt_d        = rt_q;
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    first_d     = first_q;
    req_d       = req_q;
    ret_dl_d    = ret_dl_q;
    q_pop_o     = 1'b0;
    p_ctl = '0; r_ctl = '0; f_ctl = '0;
    p_id = '0; p_key = '0; p_aux = '0;
    r_id = '0; r_key = '0; r_rem = '0;
    f_id = '0; f_rem = '0;
    wr = 1'b0; wr_status = STAT_OK; wr_id = '0; wr_rt = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          req_d   = q_req_i;
          unique case (q_req_i.op)
            OP_TICK: begin
              if (clock_q != '1) begin
                clock_d = clock_q + TIME_W'(1);
              end
              wr = 1'b1; wr_status = STAT_TICK;
            end
            OP_CREATE_PLAIN, OP_CREATE_RT: begin
              wr = 1'b1;
              if (!free_found) begin
                wr_status = STAT_FULL;
              end else begin
                used_d[free_id] = 1'b1;
                wr_id = free_id;
                if (q_req_i.op == OP_CREATE_PLAIN) begin
                  rt_d[free_id] = 1'b0;
                  f_ctl.app = 1'b1; f_id = free_id;
                end else begin
                  rt_d[free_id] = 1'b1;
                  wr_rt = 1'b1;
                  p_ctl.ins = 1'b1; p_id = free_id;
                  p_key = q_req_i.start_ms; p_aux = dl_sat;
                end
              end
            end
            OP_SELECT: state_d = S_REL1;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_REL1, S_REL2: begin
        // one due task moves from pending to ready per cycle
        if ((p_len != '0) && (p_head_key <= clock_q)) begin
          p_ctl.pop = 1'b1;
          r_ctl.ins = 1'b1; r_id = p_head_id; r_key = p_head_aux;
        end else begin
          state_d = (state_q == S_REL1) ? S_RET : S_PICK;
        end
      end
      S_RET: begin
        if (first_q) begin
          first_d = 1'b0;
          state_d = S_JUMP;
        end else if (!run_valid_q) begin
          state_d = S_JUMP;
        end else begin
          if (rt_q[run_id_q]) begin
            r_ctl.rem = 1'b1; r_rem = run_id_q;
            ret_dl_d = r_found;
          end else begin
            f_ctl.rem = 1'b1; f_rem = run_id_q;
          end
          state_d = S_REQ;
        end
      end
      S_REQ: begin
        if (req_q.task_done) begin
          if (rt_q[run_id_q]) begin
            if (clock_q <= ret_dl_q) begin
              if (met_q != '1) met_d = met_q + TIME_W'(1);
            end else begin
              if (miss_q != '1) miss_d = miss_q + TIME_W'(1);
            end
          end
          used_d[run_id_q] = 1'b0;
          rt_d[run_id_q]   = 1'b0;
        end else if (rt_q[run_id_q]) begin
          r_ctl.ins = 1'b1; r_id = run_id_q; r_key = ret_dl_q;
        end else begin
          f_ctl.app = 1'b1; f_id = run_id_q;
        end
        run_valid_d = 1'b0;
        state_d     = S_JUMP;
      end
      S_JUMP: begin
        // only pending work left: skip ahead to the earliest release
        if ((r_len == '0) && (f_len == '0) && (p_len != '0) && (p_head_key > clock_q)) begin
          clock_d = p_head_key;
        end
        state_d = S_REL2;
      end
      S_PICK: begin
        wr = 1'b1;
        if (r_len != '0) begin
          run_valid_d = 1'b1; run_id_d = r_head_id;
          wr_id = r_head_id; wr_rt = rt_q[r_head_id];
        end else if (f_len != '0) begin
          run_valid_d = 1'b1; run_id_d = f_head_id;
          wr_id = f_head_id; wr_rt = rt_q[f_head_id];
        end else begin
          run_valid_d = 1'b0;
          wr_status   = STAT_IDLE;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (wr) begin
      out_valid_d       = 1'b1;
      out_d.status      = wr_status;
      out_d.task_id     = TASK_ID_W'(wr_id);
      out_d.is_realtime = wr_rt;
      out_d.now_ms      = clock_d;
      out_d.met_count   = met_d;
      out_d.miss_count  = miss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    ret_dl_q <= ret_dl_d;
    out_q    <= out_d;
    run_id_q <= run_id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clock_q     <= '0;
      met_q       <= '0;
      miss_q      <= '0;
      used_q      <= '0;
      rt_q        <= '0;
      run_valid_q <= 1'b0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clock_q     <= clock_d;
      met_q       <= met_d;
      miss_q      <= miss_d;
      used_q      <= used_d;
      rt_q        <= rt_d;
      run_valid_q <= run_valid_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  `EDF_ASSERT(a_lists_match_slots, clk_i, rst_ni, (state_q == S_IDLE) |-> ($countones(used_q) == (int'(p_len) + int'(r_len) + int'(f_len))))
  `EDF_ASSERT(a_running_slot_used, clk_i, rst_ni, run_valid_q |-> used_q[run_id_q])
  `EDF_ASSERT(a_clock_monotonic, clk_i, rst_ni, clock_q >= $past(clock_q))
  `EDF_NEVER(a_pop_only_idle, clk_i, rst_ni, (state_q != S_IDLE) && q_pop_o)

endmodule
`default_nettype wire
